FILE: rtl/core/smm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg: shared types and constants for the square matrix multiply core
// Element widths, store geometry, input kinds, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package smm_pkg;

    // Index width of a row or column and the store geometry derived from it
    localparam int DIM_W    = 4;
    localparam int MAX_N    = 2 ** DIM_W;
    localparam int ADDR_W   = 2 * DIM_W;
    localparam int DEPTH    = MAX_N * MAX_N;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int SIZE_W   = 5;
    localparam int TDATA_W  = 2 * DIM_W + DATA_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_N);

    // Input beat kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_WR_A    = 2'd0,
        KIND_WR_B    = 2'd1,
        KIND_ROW_REQ = 2'd2
    } kind_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic              acc_clr;
        logic              out_load;
        logic [DIM_W-1:0]  out_row;
        logic [DIM_W-1:0]  out_col;
        logic              out_last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/core/smm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/smm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_datapath: element stores, multiply-accumulate unit and output register
// Two RAMs hold A and B; one read pair per cycle feeds a registered multiply
// and a wrapping 32-bit accumulator. The output register holds one result.
// ----------------------------------------------------------------------------
module smm_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  smm_pkg::cmd_t                    cmd,
    input  logic [smm_pkg::DATA_W-1:0]       wr_value,
    output smm_pkg::status_t                 status,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [smm_pkg::TDATA_W-1:0]      m_tdata,
    output logic                             m_tlast
);

    logic [smm_pkg::DATA_W-1:0] a_rdata;
    logic [smm_pkg::DATA_W-1:0] b_rdata;
    logic                       rd_valid_reg;
    logic                       prod_valid_reg;
    logic [smm_pkg::DATA_W-1:0] prod_reg;
    logic [smm_pkg::DATA_W-1:0] prod_next;
    logic [smm_pkg::DATA_W-1:0] acc_reg;
    logic                       m_valid_reg;
    logic [smm_pkg::DATA_W-1:0] out_value_reg;
    logic [smm_pkg::DIM_W-1:0]  out_row_reg;
    logic [smm_pkg::DIM_W-1:0]  out_col_reg;
    logic                       out_last_reg;

    // Element stores
    smm_ram #(
        .WIDTH (smm_pkg::DATA_W),
        .DEPTH (smm_pkg::DEPTH)
    ) u_a_ram (
        .aclk  (aclk),
        .we    (cmd.wr_a),
        .waddr (cmd.wr_addr),
        .wdata (wr_value),
        .re    (cmd.rd_en),
        .raddr (cmd.a_addr),
        .rdata (a_rdata)
    );

    smm_ram #(
        .WIDTH (smm_pkg::DATA_W),
        .DEPTH (smm_pkg::DEPTH)
    ) u_b_ram (
        .aclk  (aclk),
        .we    (cmd.wr_b),
        .waddr (cmd.wr_addr),
        .wdata (wr_value),
        .re    (cmd.rd_en),
        .raddr (cmd.b_addr),
        .rdata (b_rdata)
    );

    // Low word of the product; signed and unsigned agree there
    assign prod_next = a_rdata * b_rdata;

    // Track which pipeline stages hold a live term
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg   <= cmd.rd_en;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    // Register the product, then accumulate with wraparound
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (prod_valid_reg) begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    // Output register: load a finished element, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_value_reg <= acc_reg;
            out_row_reg   <= cmd.out_row;
            out_col_reg   <= cmd.out_col;
            out_last_reg  <= cmd.out_last;
        end
    end

    assign status.pipe_busy = rd_valid_reg | prod_valid_reg;
    assign status.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_value_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/core/smm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_ctrl: sequencer for element writes and product-row requests
// Holds the size register, decodes input beats and steps the row, column and
// k counters that drive the datapath's read addresses and result loads.
// ----------------------------------------------------------------------------
module smm_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [smm_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [smm_pkg::KIND_W-1:0]    s_kind,
    input  logic [smm_pkg::DIM_W-1:0]     s_row,
    input  logic [smm_pkg::DIM_W-1:0]     s_col,
    output smm_pkg::cmd_t                 cmd,
    input  smm_pkg::status_t              status
);

    smm_pkg::state_t              state_reg, state_next;
    logic [smm_pkg::SIZE_W-1:0]   size_reg;
    logic [smm_pkg::SIZE_W-1:0]   n_reg, n_next;
    logic [smm_pkg::DIM_W-1:0]    row_reg, row_next;
    logic [smm_pkg::DIM_W-1:0]    col_reg, col_next;
    logic [smm_pkg::DIM_W-1:0]    k_reg, k_next;
    logic [smm_pkg::SIZE_W-1:0]   eff_size;
    logic                         req_start;
    logic                         k_last;
    logic                         col_last;
    logic                         drain_done;
    smm_pkg::kind_t               kind;

    assign cfg_ready = 1'b1;
    assign kind      = smm_pkg::kind_t'(s_kind);

    // Size in use, capped at the store dimension
    assign eff_size = (size_reg > smm_pkg::SIZE_W'(smm_pkg::MAX_N))
                      ? smm_pkg::SIZE_W'(smm_pkg::MAX_N) : size_reg;

    assign req_start  = (state_reg == smm_pkg::ST_IDLE) && s_tvalid
                        && (kind == smm_pkg::KIND_ROW_REQ)
                        && ({1'b0, s_row} < eff_size);
    assign k_last     = (smm_pkg::SIZE_W'(k_reg) + 1'b1) == n_reg;
    assign col_last   = (smm_pkg::SIZE_W'(col_reg) + 1'b1) == n_reg;
    assign drain_done = !status.pipe_busy && status.out_free;

    // Size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= smm_pkg::SIZE_RESET;
        end else if (cfg_valid) begin
            size_reg <= cfg_data;
        end
    end

    // State and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smm_pkg::ST_IDLE;
            n_reg     <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            smm_pkg::ST_IDLE: begin
                if (req_start) begin
                    state_next = smm_pkg::ST_ISSUE;
                end
            end
            smm_pkg::ST_ISSUE: begin
                if (k_last) begin
                    state_next = smm_pkg::ST_DRAIN;
                end
            end
            smm_pkg::ST_DRAIN: begin
                if (drain_done) begin
                    state_next = col_last ? smm_pkg::ST_IDLE : smm_pkg::ST_ISSUE;
                end
            end
            default: state_next = smm_pkg::ST_IDLE;
        endcase
    end

    // Advance row, column and k counters
    always_comb begin
        n_next   = n_reg;
        row_next = row_reg;
        col_next = col_reg;
        k_next   = k_reg;
        if (req_start) begin
            n_next   = eff_size;
            row_next = s_row;
            col_next = '0;
            k_next   = '0;
        end else if (state_reg == smm_pkg::ST_ISSUE) begin
            k_next = k_last ? '0 : k_reg + 1'b1;
        end else if (state_reg == smm_pkg::ST_DRAIN && drain_done && !col_last) begin
            col_next = col_reg + 1'b1;
        end
    end

    // Outputs: handshake and datapath commands
    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.wr_addr  = {s_row, s_col};
        cmd.a_addr   = {row_reg, k_reg};
        cmd.b_addr   = {k_reg, col_reg};
        cmd.out_row  = row_reg;
        cmd.out_col  = col_reg;
        cmd.out_last = col_last;
        unique case (state_reg)
            smm_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.acc_clr = req_start;
                unique case (kind)
                    smm_pkg::KIND_WR_A: cmd.wr_a = s_tvalid;
                    smm_pkg::KIND_WR_B: cmd.wr_b = s_tvalid;
                    default: ;
                endcase
            end
            smm_pkg::ST_ISSUE: begin
                cmd.rd_en = 1'b1;
            end
            smm_pkg::ST_DRAIN: begin
                cmd.out_load = drain_done;
                cmd.acc_clr  = drain_done;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/square_matrix_multiply_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_matrix_multiply_core: signed 32-bit square matrix multiply, by rows
// Beats write elements of A or B; a row request returns that row of A*B.
//
//   Channel   Handshake            Payload
//   s_        s_tvalid/s_tready    s_tuser kind; s_tdata row, col, value
//   m_        m_tvalid/m_tready    m_tdata out_row, out_col, product_value;
//                                  m_tlast last
//   cfg_      cfg_valid/cfg_ready  cfg_data matrix_size
//
// A row request uses one multiply-accumulate unit, one term per cycle while
// issuing, with a drain of the RAM read and multiply stages after each column.
// A stalled m_ side holds the drain until the output register frees.
// Reset clears control state only; store contents are undefined until written.
// ----------------------------------------------------------------------------
module square_matrix_multiply_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [smm_pkg::SIZE_W-1:0]      cfg_data,   // matrix_size
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [smm_pkg::TDATA_W-1:0]     s_tdata,    // row[3:0], col[7:4], value[39:8]
    input  logic [smm_pkg::KIND_W-1:0]      s_tuser,    // kind[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [smm_pkg::TDATA_W-1:0]     m_tdata,    // out_row[3:0], out_col[7:4],
                                                        // product_value[39:8]
    output logic                            m_tlast
);

    smm_pkg::cmd_t               cmd;
    smm_pkg::status_t            status;
    logic [smm_pkg::DIM_W-1:0]   s_row;
    logic [smm_pkg::DIM_W-1:0]   s_col;
    logic [smm_pkg::DATA_W-1:0]  s_value;

    // Unpack the input beat
    assign s_row   = s_tdata[smm_pkg::DIM_W-1:0];
    assign s_col   = s_tdata[2*smm_pkg::DIM_W-1:smm_pkg::DIM_W];
    assign s_value = s_tdata[smm_pkg::TDATA_W-1:2*smm_pkg::DIM_W];

    smm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_kind    (s_tuser),
        .s_row     (s_row),
        .s_col     (s_col),
        .cmd       (cmd),
        .status    (status)
    );

    smm_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .wr_value (s_value),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The MAC pipeline is empty whenever input beats are taken
    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        status.pipe_busy |-> !s_tready)
        else $error("MAC pipeline busy while accepting input");

    // A result is loaded only after its last term has been accumulated
    a_load_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !status.pipe_busy)
        else $error("result loaded with terms still in flight");

    // Store reads never overlap store writes
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> !(cmd.wr_a || cmd.wr_b))
        else $error("store read and write in the same cycle");

    // A loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");

endmodule

FILE: tb/sv/smm_product_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_product_checker: scoreboard for the square matrix multiply core
// Watches the config, input and result channels. Mirrors the A and B element
// stores and the matrix size, computes every element of a product row requested
// inside the active size when the request beat is accepted, and compares each
// result beat, field by field, with the oldest predicted element.
// ----------------------------------------------------------------------------
module smm_product_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [smm_pkg::SIZE_W-1:0]  cfg_data,   // matrix_size
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [smm_pkg::TDATA_W-1:0] s_tdata,    // row[3:0], col[7:4], value[39:8]
    input  logic [smm_pkg::KIND_W-1:0]  s_tuser,    // kind[1:0]
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [smm_pkg::TDATA_W-1:0] m_tdata,    // out_row[3:0], out_col[7:4],
                                                    // product_value[39:8]
    input  logic                        m_tlast,
    output int                          mismatch_count,
    output int                          products_pending
);

    localparam int DIM_W  = smm_pkg::DIM_W;
    localparam int DATA_W = smm_pkg::DATA_W;

    typedef struct packed {
        logic [DIM_W-1:0]  row;
        logic [DIM_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              last;
    } product_elem_t;

    product_elem_t               product_q [$];
    logic [DATA_W-1:0]           a_elems [0:smm_pkg::DEPTH-1];
    logic [DATA_W-1:0]           b_elems [0:smm_pkg::DEPTH-1];
    logic [smm_pkg::SIZE_W-1:0]  size_reg;

    initial begin
        mismatch_count   = 0;
        products_pending = 0;
        size_reg         = smm_pkg::SIZE_RESET;
        for (int i = 0; i < smm_pkg::DEPTH; i++) begin
            a_elems[i] = '0;
            b_elems[i] = '0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns  smm checker: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Size in use: register value capped at the store dimension
    function automatic int unsigned active_size(input logic [smm_pkg::SIZE_W-1:0] s);
        return (s > smm_pkg::MAX_N) ? smm_pkg::MAX_N : s;
    endfunction

    // Queue every element of one product row, wrapping at 32 bits
    task automatic predict_product_row(input logic [DIM_W-1:0] row);
        int unsigned       n;
        logic [DATA_W-1:0] acc;
        product_elem_t     elem;
        n = active_size(size_reg);
        if (row < n) begin
            for (int unsigned c = 0; c < n; c++) begin
                acc = '0;
                for (int unsigned k = 0; k < n; k++)
                    acc = acc + a_elems[{row, DIM_W'(k)}] * b_elems[{DIM_W'(k), DIM_W'(c)}];
                elem.row   = row;
                elem.col   = DIM_W'(c);
                elem.value = acc;
                elem.last  = (c + 1 == n);
                product_q.push_back(elem);
            end
        end
    endtask

    always @(posedge aclk) begin
        product_elem_t     want;
        logic [DIM_W-1:0]  in_row;
        logic [DIM_W-1:0]  in_col;
        logic [DATA_W-1:0] in_value;
        logic [DIM_W-1:0]  got_row;
        logic [DIM_W-1:0]  got_col;
        logic [DATA_W-1:0] got_value;

        if (!aresetn) begin
            size_reg = smm_pkg::SIZE_RESET;
            product_q.delete();
        end else begin
            // Compare result beat with the oldest prediction
            if (m_tvalid && m_tready) begin
                got_row   = m_tdata[DIM_W-1:0];
                got_col   = m_tdata[2*DIM_W-1:DIM_W];
                got_value = m_tdata[2*DIM_W +: DATA_W];
                if (product_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat row %0d col %0d value 0x%08h",
                                              got_row, got_col, got_value));
                end else begin
                    want = product_q.pop_front();
                    if (got_row !== want.row)
                        report_mismatch($sformatf("out_row got %0d expected %0d",
                                                  got_row, want.row));
                    if (got_col !== want.col)
                        report_mismatch($sformatf("out_col got %0d expected %0d (row %0d)",
                                                  got_col, want.col, want.row));
                    if (got_value !== want.value)
                        report_mismatch($sformatf("product at (%0d,%0d) got 0x%08h expected 0x%08h",
                                                  want.row, want.col, got_value, want.value));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("tlast at (%0d,%0d) got %b expected %b",
                                                  want.row, want.col, m_tlast, want.last));
                end
            end

            // Apply an input beat: store an element or predict a row
            if (s_tvalid && s_tready) begin
                in_row   = s_tdata[DIM_W-1:0];
                in_col   = s_tdata[2*DIM_W-1:DIM_W];
                in_value = s_tdata[2*DIM_W +: DATA_W];
                case (s_tuser)
                    smm_pkg::KIND_WR_A:    a_elems[{in_row, in_col}] = in_value;
                    smm_pkg::KIND_WR_B:    b_elems[{in_row, in_col}] = in_value;
                    smm_pkg::KIND_ROW_REQ: predict_product_row(in_row);
                    default: ;
                endcase
            end

            // Track the size register; a request on the same edge sees the old size
            if (cfg_valid && cfg_ready)
                size_reg = cfg_data;
        end
        products_pending = product_q.size();
    end

endmodule

FILE: tb/sv/tb_square_matrix_multiply_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_square_matrix_multiply_core: stimulus and verdict for the matrix core
// Drives element writes, row requests and stray beats through several matrix
// sizes and idle/stall patterns, tracks which store entries hold data so a
// request never reads an unwritten one, and leaves checking to the scoreboard.
// ----------------------------------------------------------------------------
module tb_square_matrix_multiply_core;

    localparam int           DIM_W        = smm_pkg::DIM_W;
    localparam int           DATA_W       = smm_pkg::DATA_W;
    localparam int           MAX_N        = smm_pkg::MAX_N;
    localparam int           CYCLE_LIMIT  = 1_000_000;
    localparam int           DRAIN_CYCLES = 320;
    localparam int           NUM_PHASES   = 10;
    localparam logic [1:0]   KIND_UNUSED  = 2'd3;

    // Idle patterns, one per phase in turn
    localparam int MODE_NONE  = 0;
    localparam int MODE_SEND  = 1;
    localparam int MODE_RECV  = 2;
    localparam int MODE_BOTH  = 3;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [smm_pkg::SIZE_W-1:0]  cfg_data;      // matrix_size
    logic                        s_tvalid;
    logic                        s_tready;
    logic [smm_pkg::TDATA_W-1:0] s_tdata;       // row[3:0], col[7:4], value[39:8]
    logic [smm_pkg::KIND_W-1:0]  s_tuser;       // kind[1:0]
    logic                        m_tvalid;
    logic                        m_tready;
    logic [smm_pkg::TDATA_W-1:0] m_tdata;       // out_row[3:0], out_col[7:4],
                                                // product_value[39:8]
    logic                        m_tlast;

    int          mismatch_count;
    int          products_pending;
    int          cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    bit          a_written [0:smm_pkg::DEPTH-1];
    bit          b_written [0:smm_pkg::DEPTH-1];

    int unsigned phase_size  [0:NUM_PHASES-1] = '{3, 1, 6, 0, 8, 2, 16, 31, 4, 5};
    int unsigned phase_items [0:NUM_PHASES-1] = '{20, 15, 20, 10, 25, 15, 250, 20, 15, 15};

    square_matrix_multiply_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    smm_product_checker scoreboard (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .mismatch_count   (mismatch_count),
        .products_pending (products_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_square_matrix_multiply_core: FAIL");
            $finish;
        end
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic int unsigned active_size(input int unsigned s);
        return (s > MAX_N) ? MAX_N : s;
    endfunction

    function automatic logic [DATA_W-1:0] element_value();
        if ($urandom_range(0, 9) != 0)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'h0000_0001;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // A row may be requested once every entry it reads holds data
    function automatic bit row_ready(input int unsigned row, input int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            if (!a_written[row * MAX_N + k])
                return 1'b0;
            for (int unsigned c = 0; c < n; c++)
                if (!b_written[k * MAX_N + c])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic set_idle_mode(input int mode);
        send_idle_pct  = (mode == MODE_SEND) ? 82 : (mode == MODE_BOTH) ? 10 : 0;
        recv_stall_pct = (mode == MODE_RECV) ? 82 : (mode == MODE_BOTH) ? 10 : 0;
    endtask

    // Drop valid and hold until every predicted element has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (products_pending != 0);
    endtask

    // Send one input beat; entered and left at a falling edge
    task automatic send_beat(input logic [1:0] kind, input logic [DIM_W-1:0] row,
                             input logic [DIM_W-1:0] col, input logic [DATA_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {value, col, row};
        if (kind == smm_pkg::KIND_WR_A)
            a_written[{row, col}] = 1'b1;
        else if (kind == smm_pkg::KIND_WR_B)
            b_written[{row, col}] = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Write matrix_size once the core is idle
    task automatic write_matrix_size(input int unsigned size);
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= smm_pkg::SIZE_W'(size);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Element write anywhere, mostly inside the active square
    task automatic stray_write(input int unsigned n);
        logic [1:0] kind;
        int unsigned r, c;
        kind = $urandom_range(0, 1) ? smm_pkg::KIND_WR_B : smm_pkg::KIND_WR_A;
        if (n > 0 && $urandom_range(0, 9) != 0) begin
            r = $urandom_range(0, n - 1);
            c = $urandom_range(0, n - 1);
        end else begin
            r = $urandom_range(0, MAX_N - 1);
            c = $urandom_range(0, MAX_N - 1);
        end
        send_beat(kind, DIM_W'(r), DIM_W'(c), element_value());
    endtask

    // Fill the next unwritten entry a request will need: B first, then A by rows
    task automatic fill_write(input int unsigned n);
        for (int unsigned r = 0; r < n; r++)
            for (int unsigned c = 0; c < n; c++)
                if (!b_written[r * MAX_N + c]) begin
                    send_beat(smm_pkg::KIND_WR_B, DIM_W'(r), DIM_W'(c), element_value());
                    return;
                end
        for (int unsigned r = 0; r < n; r++)
            for (int unsigned c = 0; c < n; c++)
                if (!a_written[r * MAX_N + c]) begin
                    send_beat(smm_pkg::KIND_WR_A, DIM_W'(r), DIM_W'(c), element_value());
                    return;
                end
        stray_write(n);
    endtask

    // One random beat: mostly fills and requests, some noise
    task automatic random_beat(input int unsigned n);
        int unsigned pick, r;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            send_beat(KIND_UNUSED, DIM_W'($urandom), DIM_W'($urandom), $urandom);
        end else if (pick < 40) begin
            if (n < MAX_N && (n == 0 || $urandom_range(0, 5) == 0)) begin
                send_beat(smm_pkg::KIND_ROW_REQ, DIM_W'($urandom_range(n, MAX_N - 1)),
                          DIM_W'($urandom), element_value());
            end else begin
                r = $urandom_range(0, n - 1);
                if (row_ready(r, n))
                    send_beat(smm_pkg::KIND_ROW_REQ, DIM_W'(r), DIM_W'($urandom),
                              element_value());
                else
                    fill_write(n);
            end
        end else if (pick < 70) begin
            fill_write(n);
        end else begin
            stray_write(n);
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < smm_pkg::DEPTH; i++) begin
            a_written[i] = 1'b0;
            b_written[i] = 1'b0;
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: 2x2 product on extreme values
        set_idle_mode(MODE_NONE);
        write_matrix_size(2);
        send_beat(smm_pkg::KIND_WR_A, 4'd0, 4'd0, 32'h8000_0000);
        send_beat(smm_pkg::KIND_WR_A, 4'd0, 4'd1, 32'h7fff_ffff);
        send_beat(smm_pkg::KIND_WR_A, 4'd1, 4'd0, 32'hffff_ffff);
        send_beat(smm_pkg::KIND_WR_A, 4'd1, 4'd1, 32'h0000_0000);
        send_beat(smm_pkg::KIND_WR_B, 4'd0, 4'd0, 32'h7fff_ffff);
        send_beat(smm_pkg::KIND_WR_B, 4'd0, 4'd1, 32'h8000_0000);
        send_beat(smm_pkg::KIND_WR_B, 4'd1, 4'd0, 32'hffff_ffff);
        send_beat(smm_pkg::KIND_WR_B, 4'd1, 4'd1, 32'h0000_0001);
        // Request fields col and value carry junk that must be ignored
        send_beat(smm_pkg::KIND_ROW_REQ, 4'd0, 4'd15, 32'hffff_ffff);
        send_beat(smm_pkg::KIND_ROW_REQ, 4'd1, 4'd0, 32'h0000_0000);
        // Rows beyond the size, the unused kind, writes outside the active square
        send_beat(smm_pkg::KIND_ROW_REQ, 4'd2, 4'd0, 32'h0000_0000);
        send_beat(smm_pkg::KIND_ROW_REQ, 4'd15, 4'd15, 32'h0000_0000);
        send_beat(KIND_UNUSED, 4'd15, 4'd15, 32'hffff_ffff);
        send_beat(smm_pkg::KIND_WR_A, 4'd15, 4'd15, 32'h5555_5555);
        send_beat(smm_pkg::KIND_WR_B, 4'd15, 4'd0, 32'haaaa_aaaa);
        send_beat(smm_pkg::KIND_ROW_REQ, 4'd0, 4'd0, 32'h0000_0000);
        // Smallest size, then zero size
        write_matrix_size(1);
        send_beat(smm_pkg::KIND_ROW_REQ, 4'd0, 4'd3, 32'h1234_5678);
        send_beat(smm_pkg::KIND_ROW_REQ, 4'd1, 4'd0, 32'h0000_0000);
        write_matrix_size(0);
        send_beat(smm_pkg::KIND_ROW_REQ, 4'd0, 4'd0, 32'h0000_0000);

        // Random phases over sizes and idle patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_matrix_size(phase_size[p]);
            set_idle_mode(p % 4);
            for (int unsigned i = 0; i < phase_items[p]; i++) begin
                if (i == phase_items[p] / 2)
                    hold_until_drained();
                random_beat(active_size(phase_size[p]));
            end
        end

        // Drain and let the pipeline settle
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && products_pending == 0)
            $display("tb_square_matrix_multiply_core: PASS");
        else
            $display("tb_square_matrix_multiply_core: FAIL");
        $finish;
    end

endmodule

FILE: square_matrix_multiply_core.f
rtl/core/smm_pkg.sv
rtl/core/smm_ram.sv
rtl/core/smm_datapath.sv
rtl/core/smm_ctrl.sv
rtl/core/square_matrix_multiply_core.sv
tb/sv/smm_product_checker.sv
tb/sv/tb_square_matrix_multiply_core.sv
